@@ rtl/hgcd_pkg.sv @@
// Package for the haversine distance pipeline: widths, CORDIC constants and helpers.
// Used by every design module under rtl/ except hgcd_checker. No dependencies.
package hgcd_pkg;

  localparam int LatW = 28;
  localparam int LonW = 29;
  localparam int DistW = 31;
  localparam int CordicSteps = 30;
  localparam int PhaseW = 32;
  localparam int QW = 34; // signed Q30 working width with headroom
  localparam int RootW = 31;

  localparam logic signed [QW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [QW-1:0] Q30One = 34'sd1073741824;
  localparam logic [32:0] DistScale = 33'd5246834913;

  typedef logic signed [QW-1:0] q30_t;

  // Arctangent table in 2^32-per-turn units, one entry per CORDIC step
  function automatic logic signed [QW-1:0] atan_turn(input logic [4:0] idx);
    logic signed [QW-1:0] v;
    begin
      case (idx)
        5'd0: v = 34'sd536870912;
        5'd1: v = 34'sd316933406;
        5'd2: v = 34'sd167458907;
        5'd3: v = 34'sd85004756;
        5'd4: v = 34'sd42667331;
        5'd5: v = 34'sd21354465;
        5'd6: v = 34'sd10679838;
        5'd7: v = 34'sd5340245;
        5'd8: v = 34'sd2670163;
        5'd9: v = 34'sd1335087;
        5'd10: v = 34'sd667544;
        5'd11: v = 34'sd333772;
        5'd12: v = 34'sd166886;
        5'd13: v = 34'sd83443;
        5'd14: v = 34'sd41722;
        5'd15: v = 34'sd20861;
        5'd16: v = 34'sd10430;
        5'd17: v = 34'sd5215;
        5'd18: v = 34'sd2608;
        5'd19: v = 34'sd1304;
        5'd20: v = 34'sd652;
        5'd21: v = 34'sd326;
        5'd22: v = 34'sd163;
        5'd23: v = 34'sd81;
        5'd24: v = 34'sd41;
        5'd25: v = 34'sd20;
        5'd26: v = 34'sd10;
        5'd27: v = 34'sd5;
        5'd28: v = 34'sd3;
        5'd29: v = 34'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Q30 x Q30 product rounded back to Q30 (add half, floor shift)
  function automatic q30_t q30_mul(input q30_t a, input q30_t b);
    logic signed [2*QW-1:0] p;
    begin
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return QW'(p >>> 30);
    end
  endfunction

endpackage

@@ rtl/hgcd_phase.sv @@
// Degree-to-phase conversion: rounding division by 360 as a split reciprocal multiply,
// three register stages. Depends on hgcd_pkg.
module hgcd_phase #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int SH = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [30:0]        deg,
  output logic [hgcd_pkg::PhaseW-1:0] phase
);
  import hgcd_pkg::*;

  // phase = floor((|deg| * 2^S + 180) / 360) with S = SH - F
  //       = floor(floor((|deg| * 2^S + 180) / 8) / 45)
  localparam int Shift = SH - ANGLE_FRAC_BITS;
  localparam int RecipBits = 54;
  // ceil(2^54 / 45); exact quotient for any dividend below 2^48
  localparam logic [63:0] Recip = ((64'd1 << RecipBits) + 64'd44) / 64'd45;
  localparam logic [24:0] RecipHi = Recip[48:24];
  localparam logic [23:0] RecipLo = Recip[23:0];

  logic [30:0] mag;
  logic [63:0] t;
  logic [47:0] u_nxt;
  logic [47:0] u_r;
  logic        neg_r;
  logic        neg2_r;
  logic [48:0] pp_hh_r;
  logic [47:0] pp_hl_r;
  logic [48:0] pp_lh_r;
  logic [47:0] pp_ll_r;
  logic [97:0] sum;
  logic [31:0] p;

  // Magnitude, scaled and rounded dividend over 8
  always_comb begin
    mag   = deg[30] ? 31'(-deg) : 31'(deg);
    t     = (64'(mag) << Shift) + 64'd180;
    u_nxt = t[50:3];
  end

  // Stage 1: dividend and sign
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= deg[30];
      u_r   <= u_nxt;
    end
  end

  // Stage 2: four partial products of the reciprocal multiply
  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r  <= neg_r;
      pp_hh_r <= 49'(u_r[47:24]) * 49'(RecipHi);
      pp_hl_r <= 48'(u_r[47:24]) * 48'(RecipLo);
      pp_lh_r <= 49'(u_r[23:0]) * 49'(RecipHi);
      pp_ll_r <= 48'(u_r[23:0]) * 48'(RecipLo);
    end
  end

  // Sum the partial products; keep the quotient modulo a full turn
  always_comb begin
    sum = (98'(pp_hh_r) << 48) + ((98'(pp_hl_r) + 98'(pp_lh_r)) << 24) + 98'(pp_ll_r);
    p   = sum[85:54];
  end

  // Stage 3: phase with sign applied
  always_ff @(posedge clk) begin
    if (en) phase <= neg2_r ? 32'(-p) : p;
  end
endmodule

@@ rtl/hgcd_sincos.sv @@
// Rotation CORDIC, one register stage per micro-rotation, plus quadrant mapping.
// Depends on hgcd_pkg.
module hgcd_sincos (
  input  logic                        clk,
  input  logic                        en,
  input  logic [hgcd_pkg::PhaseW-1:0] phase,
  output hgcd_pkg::q30_t              cos_o,
  output hgcd_pkg::q30_t              sin_o
);
  import hgcd_pkg::*;

  q30_t       x_r [0:CordicSteps];
  q30_t       y_r [0:CordicSteps];
  q30_t       z_r [0:CordicSteps];
  logic [1:0] quad_r [0:CordicSteps];

  // Load start vector
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CordicGain;
      y_r[0]    <= '0;
      z_r[0]    <= QW'({2'b00, phase[29:0]});
      quad_r[0] <= phase[31:30];
    end
  end

  // Advance one micro-rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        quad_r[i+1] <= quad_r[i];
        if (!z_r[i][QW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(5'(i));
        end
      end
    end
  end

  // Map by quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      case (quad_r[CordicSteps])
        2'd0: begin cos_o <= x_r[CordicSteps];  sin_o <= y_r[CordicSteps];  end
        2'd1: begin cos_o <= -y_r[CordicSteps]; sin_o <= x_r[CordicSteps];  end
        2'd2: begin cos_o <= -x_r[CordicSteps]; sin_o <= -y_r[CordicSteps]; end
        default: begin cos_o <= y_r[CordicSteps]; sin_o <= -x_r[CordicSteps]; end
      endcase
    end
  end
endmodule

@@ rtl/hgcd_isqrt.sv @@
// Pipelined digit-by-digit square root of a Q30 value times 2^30, one result bit per stage.
// Depends on hgcd_pkg.
module hgcd_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [30:0]                val,   // Q30, 0..2^30
  output logic [hgcd_pkg::RootW-1:0] root
);
  import hgcd_pkg::*;

  localparam int Steps = 31;

  logic [61:0] rem_r [0:Steps];
  logic [61:0] res_r [0:Steps];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {val, 30'd0} > 61'd0 ? 62'({val, 30'd0}) : '0;
      res_r[0] <= '0;
    end
  end

  // bit weight 4^(Steps-1-i); all leading zero trial steps behave as the shift-down loop
  for (genvar i = 0; i < Steps; i++) begin : g_sq
    localparam logic [61:0] Bit = 62'd1 << (2 * (Steps - 1 - i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[i] >= res_r[i] + Bit) begin
          rem_r[i+1] <= rem_r[i] - (res_r[i] + Bit);
          res_r[i+1] <= (res_r[i] >> 1) + Bit;
        end else begin
          rem_r[i+1] <= rem_r[i];
          res_r[i+1] <= res_r[i] >> 1;
        end
      end
    end
  end

  assign root = res_r[Steps][RootW-1:0];
endmodule

@@ rtl/haversine_great_circle_distance.sv @@
// Top level of the haversine distance pipeline: phases, CORDIC sin/cos, haversine term,
// square roots, vectoring CORDIC and km scaling. Depends on hgcd_pkg and the hgcd_* units.
//
//  channel | dir | tdata fields (low bit first)
//  in_     | in  | lat_a[27:0] lon_a[56:28] lat_b[84:57] lon_b[113:85]
//  out_    | out | distance_km[30:0]
//
// One item enters per cycle while the output is not stalled; the depth of the pipe is set by
// the three CORDIC and square-root chains of one stage per step. All stages advance together when the
// output register is free or being emptied; a stall freezes the whole pipe, so nothing
// is lost or repeated. rst_n (synchronous) clears only the valid bits.
module haversine_great_circle_distance #(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // lat_a, lon_a, lat_b, lon_b
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // distance_km
);
  import hgcd_pkg::*;

  localparam int Lat = 3 + CordicSteps + 2 + 3 + 1 + 31 + 1 + CordicSteps + 1 + 2;

  logic en;
  logic [Lat-1:0] vld_r;

  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;
  assign out_tvalid = vld_r[Lat-1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Lat-2:0], in_tvalid};
  end

  logic signed [27:0] lat_a, lat_b;
  logic signed [28:0] lon_a, lon_b;
  assign lat_a = in_tdata[27:0];
  assign lon_a = in_tdata[56:28];
  assign lat_b = in_tdata[84:57];
  assign lon_b = in_tdata[113:85];

  logic signed [30:0] dlat, dlon;
  assign dlat = 31'(lat_b) - 31'(lat_a);
  assign dlon = 31'(lon_b) - 31'(lon_a);

  logic [31:0] ph_dlat, ph_dlon, ph_a, ph_b;
  hgcd_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .SH(31)) u_ph0 (clk, en, dlat, ph_dlat);
  hgcd_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .SH(31)) u_ph1 (clk, en, dlon, ph_dlon);
  hgcd_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .SH(32)) u_ph2 (clk, en, 31'(lat_a), ph_a);
  hgcd_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .SH(32)) u_ph3 (clk, en, 31'(lat_b), ph_b);

  q30_t c_dlat, s_dlat, c_dlon, s_dlon, c_a, s_a, c_b, s_b;
  hgcd_sincos u_sc0 (clk, en, ph_dlat, c_dlat, s_dlat);
  hgcd_sincos u_sc1 (clk, en, ph_dlon, c_dlon, s_dlon);
  hgcd_sincos u_sc2 (clk, en, ph_a, c_a, s_a);
  hgcd_sincos u_sc3 (clk, en, ph_b, c_b, s_b);

  // Haversine term: squares, product, sum and clamp over three stages
  q30_t sq_lat_r, cab_r, sq_lon_r, sq_lat2_r, prod_r, a_sum;
  logic [30:0] a_r, na;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_lat_r  <= q30_mul(s_dlat, s_dlat);
      cab_r     <= q30_mul(c_a, c_b);
      sq_lon_r  <= q30_mul(s_dlon, s_dlon);
      sq_lat2_r <= sq_lat_r;
      prod_r    <= q30_mul(cab_r, sq_lon_r);
      if (a_sum[QW-1])          a_r <= '0;
      else if (a_sum > Q30One)  a_r <= 31'(Q30One);
      else                      a_r <= a_sum[30:0];
    end
  end
  assign a_sum = sq_lat2_r + prod_r;
  assign na = 31'(Q30One) - a_r;

  logic [RootW-1:0] root_a, root_b;
  hgcd_isqrt u_sq0 (clk, en, a_r, root_a);
  hgcd_isqrt u_sq1 (clk, en, na, root_b);

  // Vectoring CORDIC on (x=root_b, y=root_a)
  q30_t vx_r [0:CordicSteps];
  q30_t vy_r [0:CordicSteps];
  q30_t vz_r [0:CordicSteps];
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= QW'(root_b);
      vy_r[0] <= QW'(root_a);
      vz_r[0] <= '0;
    end
  end
  for (genvar i = 0; i < CordicSteps; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_r[i][QW-1]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + atan_turn(5'(i));
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - atan_turn(5'(i));
        end
      end
    end
  end

  // Clamp angle, scale to km
  logic [30:0] z_r;
  logic [63:0] km_r;
  logic [30:0] dist_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (vz_r[CordicSteps][QW-1])          z_r <= '0;
      else if (vz_r[CordicSteps] > Q30One)  z_r <= 31'(Q30One);
      else                                  z_r <= vz_r[CordicSteps][30:0];
      km_r   <= 64'(z_r) * 64'(DistScale) + 64'd2147483648;
      dist_r <= km_r[62:32];
    end
  end

  assign out_tdata = {1'b0, dist_r};
endmodule

@@ rtl/hgcd_checker.sv @@
// Port-level checks for the haversine distance block, bound to the top level.
// Depends only on the top-level ports.
module hgcd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [31:0] out_tdata
);
  a_stable_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (out_tready || !out_tvalid))
    else $error("input ready does not follow output side");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31] == 1'b0)
    else $error("pad bit set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");
endmodule

bind haversine_great_circle_distance hgcd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ sim/haversine_great_circle_distance_tb.sv @@
// Testbench for haversine_great_circle_distance: drives coordinate pairs on the input
// stream and checks each distance against a bit-exact fixed-point predictor.
// Depends on the RTL top level, and through it on hgcd_pkg.
`timescale 1ns / 1ps

module haversine_great_circle_distance_tb;

  localparam int FracBits = 20;
  localparam longint LatMax = 94371840;
  localparam longint LonMax = 188743680;
  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 300;

  // Distance predictor and the queue of distances still owed by the block
  class distance_board;
    logic [30:0] owed_km[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint fshift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-(v + 1)) >>> s) - 1;
    endfunction

    static function longint qmul(longint a, longint b);
      return fshift(a * b + (64'sd1 << 29), 30);
    endfunction

    static function longint arc(int i);
      longint tbl[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};
      return tbl[i];
    endfunction

    // Degrees to a wheel phase; sh = 32 for whole angles, 31 for half angles
    static function logic [31:0] to_phase(longint deg, int sh);
      logic [63:0] mag, den, q;
      logic [31:0] p;
      mag = (deg < 0) ? -deg : deg;
      den = 64'd360 << FracBits;
      q = ((mag << sh) + den / 2) / den;
      p = q[31:0];
      return (deg < 0) ? -p : p;
    endfunction

    static function void rotate(logic [31:0] ph, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = ph[29:0];
      for (int i = 0; i < 30; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= arc(i);
        end else begin
          x += dx; y -= dy; z += arc(i);
        end
      end
      case (ph[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    static function longint root(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b; res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    static function logic [30:0] distance(longint la, longint oa, longint lb, longint ob);
      longint cdl, sdl, cdo, sdo, ca, sa, cb, sb, a, ra, rb, x, y, z, dx, dy;
      logic [63:0] prod;
      rotate(to_phase(lb - la, 31), cdl, sdl);
      rotate(to_phase(ob - oa, 31), cdo, sdo);
      rotate(to_phase(la, 32), ca, sa);
      rotate(to_phase(lb, 32), cb, sb);
      a = qmul(sdl, sdl) + qmul(qmul(ca, cb), qmul(sdo, sdo));
      if (a < 0) a = 0;
      if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
      ra = root(a << 30);
      rb = root(((64'sd1 << 30) - a) << 30);
      // vectoring pass: y = sqrt(a), x = sqrt(1-a)
      y = ra; x = rb; z = 0;
      for (int i = 0; i < 30; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += arc(i);
        end else begin
          x -= dx; y += dy; z -= arc(i);
        end
      end
      if (z < 0) z = 0;
      if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
      prod = (64'(z) * 64'd5246834913 + (64'd1 << 31)) >> 32;
      return prod[30:0];
    endfunction

    function void note_pair(logic [119:0] d);
      note_owed(distance($signed(d[27:0]), $signed(d[56:28]),
                         $signed(d[84:57]), $signed(d[113:85])));
    endfunction

    function void note_owed(logic [30:0] km);
      owed_km.push_back(km);
    endfunction

    function void check_distance(logic [31:0] got);
      logic [30:0] want;
      if (owed_km.size() == 0) begin
        $display("%0t: unexpected distance %0d", $time, got);
        errors++;
        return;
      end
      want = owed_km.pop_front();
      if (got[30:0] !== want) begin
        $display("%0t: distance_km expected %0d actual %0d", $time, want, got[30:0]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [119:0] in_tdata;   // lat_a, lon_a, lat_b, lon_b
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;   // distance_km

  distance_board board;
  int cycles;

  haversine_great_circle_distance #(.ANGLE_FRAC_BITS(FracBits)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one pair: hold valid until the handshake, then idle for a random gap
  task automatic send_pair(longint la, longint oa, longint lb, longint ob);
    int g;
    in_tdata <= {6'd0, 29'(ob), 28'(lb), 29'(oa), 28'(la)};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_pair({6'd0, 29'(ob), 28'(lb), 29'(oa), 28'(la)});
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic longint rnd_span(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  // Any bit pattern of the field, beyond the nominal range too
  function automatic longint rnd_raw(int w);
    logic [31:0] r;
    r = $urandom();
    r = r & ((32'd1 << w) - 1);
    return r[w-1] ? longint'(r) - (64'sd1 << w) : longint'(r);
  endfunction

  // Check every accepted distance at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_distance(out_tdata);
    end
  end

  // Random receiver stalls, changed at the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b1;
    else out_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("haversine_great_circle_distance test failed");
      $finish;
    end
  end

  initial begin
    longint la, oa, lb, ob;
    int k;
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: same point, poles, antipodes, date line, field extremes, wrap-around
    send_pair(0, 0, 0, 0);
    send_pair(LatMax, 0, -LatMax, 0);
    send_pair(0, 0, 0, LonMax);
    send_pair(0, -LonMax, 0, LonMax);
    send_pair(0, LonMax - 1, 0, -LonMax + 1);
    send_pair(LatMax, LonMax, LatMax, -LonMax);
    send_pair(-LatMax, -LonMax, -LatMax, LonMax);
    send_pair(0, 0, 1, 0);
    send_pair(0, 0, 0, 1);
    send_pair(0, 0, 0, -1);
    send_pair(LatMax, 0, LatMax - 1, 0);
    send_pair(45 <<< FracBits, 10 <<< FracBits, -45 <<< FracBits, -170 <<< FracBits);
    send_pair(-(1 <<< 27), -(1 <<< 28), (1 <<< 27) - 1, (1 <<< 28) - 1);
    send_pair((1 <<< 27) - 1, (1 <<< 28) - 1, -(1 <<< 27), -(1 <<< 28));
    send_pair(-(1 <<< 27), 0, -(1 <<< 27), -(1 <<< 28));
    send_pair(48 <<< FracBits, 2 <<< FracBits, 40 <<< FracBits, -74 <<< FracBits);
    send_pair(1, 1, -1, -1);
    send_pair(-1, -1, -1, -1);

    // Random: mostly in-range pairs, some close pairs, some raw bit patterns
    for (int n = 0; n < 1600; n++) begin
      k = $urandom_range(0, 9);
      la = rnd_span(LatMax);
      oa = rnd_span(LonMax);
      if (k < 6) begin
        lb = rnd_span(LatMax);
        ob = rnd_span(LonMax);
      end else if (k < 8) begin
        lb = la + $urandom_range(0, 2000) - 1000;
        ob = oa + $urandom_range(0, 2000) - 1000;
        if (lb > LatMax || lb < -LatMax) lb = la;
        if (ob > LonMax || ob < -LonMax) ob = oa;
      end else begin
        la = rnd_raw(28);
        oa = rnd_raw(29);
        lb = rnd_raw(28);
        ob = rnd_raw(29);
      end
      send_pair(la, oa, lb, ob);
    end
    in_tvalid <= 1'b0;

    while (board.owed_km.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0) $display("haversine_great_circle_distance test passed");
    else $display("haversine_great_circle_distance test failed");
    $finish;
  end

endmodule

@@ haversine_great_circle_distance.f @@
rtl/hgcd_pkg.sv
rtl/hgcd_phase.sv
rtl/hgcd_sincos.sv
rtl/hgcd_isqrt.sv
rtl/haversine_great_circle_distance.sv
rtl/hgcd_checker.sv
sim/haversine_great_circle_distance_tb.sv
